@@ rtl/core/adad_pkg.sv @@
package adad_pkg;

    localparam int IDX_W  = 10;
    localparam int DATA_W = 32;
    localparam int AVG_W  = 48;
    localparam int BETA_W = 16;
    localparam int EPS_W  = 33;
    localparam int RAD_W  = 64;
    localparam int ROOT_W = 32;
    localparam int REM_W  = 34;
    localparam int QUO_W  = 33;

    localparam int SQRT_STAGES = 32;
    localparam int DIV_STAGES  = 33;

    localparam logic [0:0] REG_BETA = 1'b0;
    localparam logic [0:0] REG_EPS  = 1'b1;

    localparam logic [BETA_W-1:0] BETA_RST = 16'd58982;
    localparam logic [EPS_W-1:0]  EPS_RST  = 33'd4295;
    localparam logic [AVG_W-1:0]  AVG_MAX  = {AVG_W{1'b1}};

    typedef struct packed {
        logic [IDX_W-1:0]         raw_idx;
        logic [IDX_W-1:0]         red_idx;
        logic                     g_neg;
        logic [DATA_W-1:0]        g_mag;
        logic signed [DATA_W-1:0] w;
    } tag_t;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [RAD_W-1:0]  rad;
    } sqrt_st_t;

    typedef struct packed {
        logic [ROOT_W-1:0] rem;
        logic [QUO_W-1:0]  q;
        logic [QUO_W-1:0]  num_lo;
    } div_st_t;

    // one result bit of the digit-by-digit root
    function automatic sqrt_st_t sqrt_step(sqrt_st_t a);
        logic [REM_W+1:0] cur;
        logic [REM_W+1:0] trial;
        sqrt_st_t r;
        cur   = {a.rem, a.rad[RAD_W-1:RAD_W-2]};
        trial = {2'b00, a.root, 2'b01};
        r.rad = {a.rad[RAD_W-3:0], 2'b00};
        if (cur >= trial) begin
            r.rem  = REM_W'(cur - trial);
            r.root = {a.root[ROOT_W-2:0], 1'b1};
        end else begin
            r.rem  = cur[REM_W-1:0];
            r.root = {a.root[ROOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

    // one quotient bit of restoring division
    function automatic div_st_t div_step(div_st_t a, logic [ROOT_W-1:0] den);
        logic [ROOT_W:0] cur;
        div_st_t r;
        cur      = {a.rem, a.num_lo[QUO_W-1]};
        r.num_lo = {a.num_lo[QUO_W-2:0], 1'b0};
        if (cur >= {1'b0, den}) begin
            r.rem = ROOT_W'(cur - {1'b0, den});
            r.q   = {a.q[QUO_W-2:0], 1'b1};
        end else begin
            r.rem = cur[ROOT_W-1:0];
            r.q   = {a.q[QUO_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

@@ rtl/core/adad_sqrt_pipe.sv @@
module adad_sqrt_pipe
    import adad_pkg::*;
(
    input  logic              aclk,
    input  logic              en,
    input  logic [RAD_W-1:0]  rad_in,
    output logic [ROOT_W-1:0] root_out
);

    sqrt_st_t st_reg [SQRT_STAGES];
    sqrt_st_t first;

    assign first    = '{rem: '0, root: '0, rad: rad_in};
    assign root_out = st_reg[SQRT_STAGES-1].root;

    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg[0] <= sqrt_step(first);
            for (int k = 1; k < SQRT_STAGES; k++) begin
                st_reg[k] <= sqrt_step(st_reg[k-1]);
            end
        end
    end

endmodule

@@ rtl/core/adad_div_pipe.sv @@
module adad_div_pipe
    import adad_pkg::*;
(
    input  logic              aclk,
    input  logic              en,
    input  logic [RAD_W-1:0]  num_in,
    input  logic [ROOT_W-1:0] den_in,
    output logic [QUO_W-1:0]  q_out,
    output logic              ov_out
);

    div_st_t           st_reg  [DIV_STAGES];
    logic [ROOT_W-1:0] den_reg [DIV_STAGES];
    logic              ov_reg  [DIV_STAGES];
    div_st_t           first;
    logic              first_ov;

    // quotient of 2^33 or more saturates anyway
    assign first    = '{rem: {1'b0, num_in[RAD_W-1:QUO_W]}, q: '0,
                        num_lo: num_in[QUO_W-1:0]};
    assign first_ov = ({1'b0, num_in[RAD_W-1:QUO_W]} >= den_in);
    assign q_out    = st_reg[DIV_STAGES-1].q;
    assign ov_out   = ov_reg[DIV_STAGES-1];

    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg[0]  <= div_step(first, den_in);
            den_reg[0] <= den_in;
            ov_reg[0]  <= first_ov;
            for (int k = 1; k < DIV_STAGES; k++) begin
                st_reg[k]  <= div_step(st_reg[k-1], den_reg[k-1]);
                den_reg[k] <= den_reg[k-1];
                ov_reg[k]  <= ov_reg[k-1];
            end
        end
    end

endmodule

@@ rtl/core/adadelta_weight_update.sv @@
// Throughput: one item per cycle unless m_tready stalls the output; an item whose element
// is still in flight waits at the element-store read until the earlier item has written
// its step back. Reset (aresetn low, synchronous) restores beta and epsilon, then the
// element stores are zeroed, one entry per cycle until all ELEMENTS entries are clear,
// with s_tready low.
module adadelta_weight_update
    import adad_pkg::*;
#(
    parameter int ELEMENTS = 1024
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [79:0]      s_tdata,   // elem_index, gradient, weight_in
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [47:0]      m_tdata,   // index_out, weight_out
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [0:0]       cfg_index,
    input  logic [EPS_W-1:0] cfg_data
);

    localparam int AW       = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;
    localparam int ST_R2    = 1;
    localparam int ST_M     = 2;
    localparam int ST_P1    = 3;
    localparam int ST_P2    = 4;
    localparam int ST_P3    = 5;
    localparam int ST_ROOT  = ST_P3 + SQRT_STAGES;
    localparam int ST_MUL   = ST_ROOT + 1;
    localparam int ST_LAST  = ST_MUL + DIV_STAGES;
    localparam int NST      = ST_LAST + 1;

    logic [BETA_W-1:0] beta_reg;
    logic [EPS_W-1:0]  eps_reg;

    logic          vld_reg [NST];
    tag_t          tag_reg [NST];
    tag_t          tag0_next;
    tag_t          tag1_next;

    logic en, front_en, haz, accept;

    logic          clr_reg;
    logic [AW-1:0] clr_cnt_reg;

    logic [AVG_W-1:0]  mem_s [ELEMENTS];
    logic [AVG_W-1:0]  mem_d [ELEMENTS];
    logic [DATA_W-1:0] mem_p [ELEMENTS];

    logic [AVG_W-1:0]        s_old_reg, d_old_reg, s_old1_reg, d_old1_reg;
    logic signed [DATA_W-1:0] p_old_reg;
    logic [DATA_W-1:0]       p_mag;
    logic [2*DATA_W-1:0]     gsq_reg, psq_reg;
    logic [63:0]             sa_reg, da_reg;
    logic [64:0]             sb_reg, db_reg;
    logic [65:0]             s_sum, d_sum;
    logic [AVG_W-1:0]        s_new, d_new;
    logic [RAD_W-1:0]        rad_s_reg, rad_d_reg;
    logic [ROOT_W-1:0]       root_s, root_d;
    logic [RAD_W-1:0]        num_reg;
    logic [ROOT_W-1:0]       den_reg;
    logic [QUO_W-1:0]        qm;
    logic                    q_ov;
    logic signed [DATA_W-1:0] step;
    logic signed [DATA_W:0]   nw_wide;
    logic signed [DATA_W-1:0] nw;

    logic                     m_tvalid_reg;
    logic [IDX_W-1:0]         idx_out_reg;
    logic signed [DATA_W-1:0] w_out_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beta_reg <= BETA_RST;
            eps_reg  <= EPS_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_BETA: beta_reg <= cfg_data[BETA_W-1:0];
                REG_EPS:  eps_reg  <= cfg_data;
                default:  ;
            endcase
        end
    end

    // pipeline control
    assign en = !m_tvalid_reg || m_tready;

    always_comb begin
        haz = 1'b0;
        for (int k = ST_M; k < NST; k++) begin
            if (vld_reg[k] && (tag_reg[k].red_idx == tag_reg[ST_R2].red_idx)) begin
                haz = 1'b1;
            end
        end
    end

    assign front_en = en && !(vld_reg[ST_R2] && haz);
    assign s_tready = front_en && !clr_reg;
    assign accept   = s_tvalid && s_tready;

    // element number folded into the store, high half here, low half in the next stage
    always_comb begin
        logic [DATA_W-1:0] g;
        logic [IDX_W-1:0]  r;
        g = s_tdata[41:10];
        r = s_tdata[9:0];
        for (int k = 9; k >= 5; k--) begin
            if (32'(r) >= 32'(ELEMENTS << k)) begin
                r = r - IDX_W'(ELEMENTS << k);
            end
        end
        tag0_next.raw_idx = s_tdata[9:0];
        tag0_next.red_idx = r;
        tag0_next.g_neg   = g[31];
        tag0_next.g_mag   = g[31] ? (~g + 32'd1) : g;
        tag0_next.w       = s_tdata[73:42];
    end

    always_comb begin
        logic [IDX_W-1:0] r;
        r = tag_reg[0].red_idx;
        for (int k = 4; k >= 0; k--) begin
            if (32'(r) >= 32'(ELEMENTS << k)) begin
                r = r - IDX_W'(ELEMENTS << k);
            end
        end
        tag1_next         = tag_reg[0];
        tag1_next.red_idx = r;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NST; k++) begin
                vld_reg[k] <= 1'b0;
            end
        end else if (en) begin
            for (int k = ST_P1; k < NST; k++) begin
                vld_reg[k] <= vld_reg[k-1];
            end
            vld_reg[ST_M] <= vld_reg[ST_R2] && !haz;
            if (front_en) begin
                vld_reg[ST_R2] <= vld_reg[0];
                vld_reg[0]     <= accept;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = ST_M; k < NST; k++) begin
                tag_reg[k] <= tag_reg[k-1];
            end
            if (front_en) begin
                tag_reg[ST_R2] <= tag1_next;
                tag_reg[0]     <= tag0_next;
            end
        end
    end

    // post-reset clearing of the element stores
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg     <= 1'b1;
            clr_cnt_reg <= '0;
        end else if (clr_reg) begin
            if (clr_cnt_reg == AW'(ELEMENTS - 1)) begin
                clr_reg <= 1'b0;
            end else begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (clr_reg) begin
            mem_s[clr_cnt_reg] <= '0;
            mem_d[clr_cnt_reg] <= '0;
            mem_p[clr_cnt_reg] <= '0;
        end else begin
            if (en && vld_reg[ST_P2]) begin
                mem_s[AW'(tag_reg[ST_P2].red_idx)] <= s_new;
                mem_d[AW'(tag_reg[ST_P2].red_idx)] <= d_new;
            end
            if (en && vld_reg[ST_LAST]) begin
                mem_p[AW'(tag_reg[ST_LAST].red_idx)] <= step;
            end
        end
        if (front_en) begin
            s_old_reg <= mem_s[AW'(tag_reg[ST_R2].red_idx)];
            d_old_reg <= mem_d[AW'(tag_reg[ST_R2].red_idx)];
            p_old_reg <= mem_p[AW'(tag_reg[ST_R2].red_idx)];
        end
    end

    // squares and running averages
    assign p_mag = p_old_reg[31] ? (~p_old_reg + 32'd1) : p_old_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            gsq_reg    <= tag_reg[ST_M].g_mag * tag_reg[ST_M].g_mag;
            psq_reg    <= p_mag * p_mag;
            s_old1_reg <= s_old_reg;
            d_old1_reg <= d_old_reg;

            sa_reg <= beta_reg * s_old1_reg;
            da_reg <= beta_reg * d_old1_reg;
            sb_reg <= (17'h10000 - {1'b0, beta_reg}) * gsq_reg[63:16];
            db_reg <= (17'h10000 - {1'b0, beta_reg}) * psq_reg[63:16];

            rad_s_reg <= {1'b0, ({1'b0, s_new} + {16'b0, eps_reg}), 14'b0};
            rad_d_reg <= {1'b0, ({1'b0, d_new} + {16'b0, eps_reg}), 14'b0};
        end
    end

    assign s_sum = {2'b00, sa_reg} + {1'b0, sb_reg};
    assign d_sum = {2'b00, da_reg} + {1'b0, db_reg};
    assign s_new = (s_sum[65:64] != 2'b00) ? AVG_MAX : s_sum[63:16];
    assign d_new = (d_sum[65:64] != 2'b00) ? AVG_MAX : d_sum[63:16];

    adad_sqrt_pipe u_sqrt_s (
        .aclk     (aclk),
        .en       (en),
        .rad_in   (rad_s_reg),
        .root_out (root_s)
    );

    adad_sqrt_pipe u_sqrt_d (
        .aclk     (aclk),
        .en       (en),
        .rad_in   (rad_d_reg),
        .root_out (root_d)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            num_reg <= tag_reg[ST_ROOT].g_mag * root_d;
            den_reg <= (root_s == '0) ? ROOT_W'(1) : root_s;
        end
    end

    adad_div_pipe u_div (
        .aclk   (aclk),
        .en     (en),
        .num_in (num_reg),
        .den_in (den_reg),
        .q_out  (qm),
        .ov_out (q_ov)
    );

    // signed, saturated step and new weight
    always_comb begin
        if (tag_reg[ST_LAST].g_neg) begin
            if (q_ov || (qm > 33'h080000000)) begin
                step = 32'sh80000000;
            end else begin
                step = -$signed(qm[31:0]);
            end
        end else begin
            if (q_ov || (qm > 33'h07FFFFFFF)) begin
                step = 32'sh7FFFFFFF;
            end else begin
                step = $signed(qm[31:0]);
            end
        end
        nw_wide = 33'(tag_reg[ST_LAST].w) - 33'(step);
        if (nw_wide[32] != nw_wide[31]) begin
            nw = nw_wide[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
        end else begin
            nw = nw_wide[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= vld_reg[ST_LAST];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            idx_out_reg <= tag_reg[ST_LAST].raw_idx;
            w_out_reg   <= nw;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, w_out_reg, idx_out_reg};

endmodule

@@ bench/tb_adadelta_weight_update.sv @@
module tb_adadelta_weight_update;
    import adad_pkg::*;

    localparam int NELEM     = 1024;
    localparam int WDOG_MAX  = 20000;
    localparam int DRAIN_CYC = 100;

    // packed from the top bit down, so the cast from s_tdata lines up
    typedef struct packed {
        logic signed [DATA_W-1:0] wgt;
        logic signed [DATA_W-1:0] grad;
        logic [IDX_W-1:0]         idx;
    } upd_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]         idx;
        logic signed [DATA_W-1:0] wgt;
    } upd_result_t;

    logic             aclk;
    logic             aresetn;
    logic             s_tvalid;
    logic             s_tready;
    logic [79:0]      s_tdata;   // elem_index, gradient, weight_in
    logic             m_tvalid;
    logic             m_tready;
    logic [47:0]      m_tdata;   // index_out, weight_out
    logic             cfg_valid;
    logic             cfg_ready;
    logic [0:0]       cfg_index;
    logic [EPS_W-1:0] cfg_data;

    adadelta_weight_update #(.ELEMENTS(NELEM)) u_dut (.*);

    upd_item_t   pending_q[$];
    upd_result_t weight_q[$];

    logic [BETA_W-1:0] beta_mdl;
    logic [EPS_W-1:0]  eps_mdl;
    logic [63:0]       grad_avg[NELEM];
    logic [63:0]       step_avg[NELEM];
    logic signed [DATA_W-1:0] last_step[NELEM];

    int  n_err;
    int  n_items;
    int  n_results;
    int  idle_cyc;
    bit  no_idle;
    bit  long_hold_req;
    bit  long_hold_done;
    int  hold_cnt;
    int  src_gap;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic logic [63:0] floor_root(logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = '0;
        b = 64'h4000_0000_0000_0000;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] mix_avg(logic [63:0] old_v, logic [63:0] sq);
        logic [65:0] acc;
        acc = (66'(beta_mdl) * 66'(old_v) + (66'(65536) - 66'(beta_mdl)) * 66'(sq)) >> 16;
        if (acc > 66'(AVG_MAX)) acc = 66'(AVG_MAX);
        return acc[63:0];
    endfunction

    task automatic predict_weight(upd_item_t it);
        logic [9:0]  e;
        logic [63:0] gm;
        logic [63:0] pm;
        logic [63:0] s;
        logic [63:0] d;
        logic [63:0] rs;
        logic [63:0] rd;
        logic [63:0] qm;
        longint      stp;
        longint      nw;
        upd_result_t res;
        e  = IDX_W'(it.idx % NELEM);
        gm = it.grad < 0 ? 64'(-longint'(it.grad)) : 64'(it.grad);
        pm = last_step[e] < 0 ? 64'(-longint'(last_step[e])) : 64'(last_step[e]);
        s  = mix_avg(grad_avg[e], (gm * gm) >> 16);
        d  = mix_avg(step_avg[e], (pm * pm) >> 16);
        grad_avg[e] = s;
        step_avg[e] = d;
        rd = floor_root((d + 64'(eps_mdl)) << 14);
        rs = floor_root((s + 64'(eps_mdl)) << 14);
        if (rs == 0) rs = 1;
        qm = (gm * rd) / rs;
        if (it.grad < 0) stp = qm > 64'd2147483648 ? -64'sd2147483648 : -longint'(qm);
        else stp = qm > 64'd2147483647 ? 64'sd2147483647 : longint'(qm);
        last_step[e] = DATA_W'(stp);
        nw = longint'(it.wgt) - stp;
        if (nw > 64'sd2147483647) nw = 64'sd2147483647;
        if (nw < -64'sd2147483648) nw = -64'sd2147483648;
        res.idx = it.idx;
        res.wgt = DATA_W'(nw);
        weight_q.push_back(res);
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
        n_err++;
    endtask

    function automatic int pick_gap();
        if (no_idle) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(8, 40);
        if ($urandom_range(0, 1) == 0) return 0;
        return $urandom_range(1, 3);
    endfunction

    // source side
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            src_gap  = 0;
        end else if (!s_tvalid || s_tready) begin
            if (src_gap > 0 || pending_q.size() == 0) begin
                if (src_gap > 0) src_gap--;
                s_tvalid <= 1'b0;
            end else begin
                upd_item_t it;
                it = pending_q.pop_front();
                s_tdata  <= {6'b0, it.wgt, it.grad, it.idx};
                s_tvalid <= 1'b1;
                src_gap  = pick_gap();
            end
        end
    end

    // sink side
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (long_hold_req && !long_hold_done && hold_cnt == 0) begin
            hold_cnt       = 400;
            long_hold_done = 1'b1;
            m_tready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= no_idle ? 1'b1 : (pick_gap() == 0);
        end
    end

    // acceptance, prediction and checking
    always @(posedge aclk) begin
        if (aresetn) begin
            idle_cyc++;
            if (cfg_valid && cfg_ready) begin
                idle_cyc = 0;
                if (cfg_index == REG_BETA) beta_mdl = cfg_data[BETA_W-1:0];
                else eps_mdl = cfg_data;
            end
            if (s_tvalid && s_tready) begin
                idle_cyc = 0;
                n_items++;
                predict_weight(upd_item_t'(s_tdata[73:0]));
            end
            if (m_tvalid && m_tready) begin
                idle_cyc = 0;
                n_results++;
                if (weight_q.size() == 0) begin
                    report_mismatch("unexpected item", m_tdata, 0);
                end else begin
                    upd_result_t w;
                    w = weight_q.pop_front();
                    if (m_tdata[9:0] != w.idx) report_mismatch("index_out", m_tdata[9:0], w.idx);
                    if (m_tdata[41:10] != w.wgt)
                        report_mismatch("weight_out", m_tdata[41:10], w.wgt);
                end
            end
            if (idle_cyc >= WDOG_MAX) begin
                $display("timeout: no handshake for %0d cycles", WDOG_MAX);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    task automatic cfg_write(logic [0:0] idx, logic [EPS_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(posedge aclk);
        while (pending_q.size() != 0 || s_tvalid || weight_q.size() != 0);
        repeat (DRAIN_CYC) @(posedge aclk);
    endtask

    task automatic push_item(int idx, int grad, int wgt);
        upd_item_t it;
        it.idx  = IDX_W'(idx);
        it.grad = grad;
        it.wgt  = wgt;
        pending_q.push_back(it);
    endtask

    task automatic push_random(int count);
        int   idx;
        int   g;
        int   w;
        repeat (count) begin
            case ($urandom_range(0, 3))
                0: idx = $urandom_range(0, NELEM - 1);
                1: idx = (NELEM - 1) - $urandom_range(0, 3);
                default: idx = $urandom_range(0, 7);
            endcase
            g = $urandom();
            if ($urandom_range(0, 2) != 0) g = g >>> $urandom_range(0, 24);
            w = $urandom();
            if ($urandom_range(0, 1) != 0) w = w >>> $urandom_range(4, 20);
            push_item(idx, g, w);
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_BETA;
        cfg_data  = '0;
        beta_mdl  = BETA_RST;
        eps_mdl   = EPS_RST;
        foreach (grad_avg[i]) begin
            grad_avg[i]  = '0;
            step_avg[i]  = '0;
            last_step[i] = '0;
        end
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // reset values first: extremes of every field, repeated elements
        push_item(0, 0, 0);
        push_item(0, 32'sh7fffffff, 32'sh7fffffff);
        push_item(0, 32'sh80000000, 32'sh80000000);
        push_item(0, 32'sh7fffffff, 32'sh80000000);
        push_item(NELEM - 1, 32'sh80000000, 32'sh7fffffff);
        push_item(NELEM - 1, -1, 1);
        push_item(NELEM - 1, 1, -1);
        push_item(5, 32'sh01000000, 32'sh01000000);
        push_item(5, 32'sh01000000, 32'sh01000000);
        push_item(5, -32'sh01000000, 0);
        push_item(5, 32'sh00000100, 0);
        push_item(5, 0, 32'sh7fffffff);
        push_item(6, 32'sh40000000, -32'sh7fffffff);
        push_item(6, 32'sh40000000, 0);
        push_item(6, -32'sh40000000, 0);
        push_item(511, 32'sh00001000, 32'sh12345678);
        push_item(512, -32'sh00001000, -32'sh12345678);
        wait_drained();

        no_idle = 1'b1;
        push_random(220);
        wait_drained();
        no_idle = 1'b0;

        cfg_write(REG_BETA, EPS_W'(1));
        cfg_write(REG_EPS, EPS_W'(1));
        push_random(260);
        wait_drained();

        cfg_write(REG_BETA, EPS_W'(65535));
        cfg_write(REG_EPS, 33'h1_0000_0000);
        long_hold_req = 1'b1;
        push_random(260);
        wait_drained();

        cfg_write(REG_BETA, EPS_W'(32768));
        cfg_write(REG_EPS, EPS_W'(EPS_RST));
        push_random(260);
        wait_drained();

        cfg_write(REG_BETA, EPS_W'($urandom_range(1, 65535)));
        cfg_write(REG_EPS, EPS_W'($urandom()) | EPS_W'(1));
        push_random(260);
        wait_drained();

        $display("covered %0d items / %0d results over five beta/eps settings incl. extremes,",
                 n_items, n_results);
        $display("random gaps on both sides, a long output stall and idle-free stretches");
        if (n_err == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
